// ===== rtl/uqd_pkg.sv =====
package uqd_pkg;

  // Result kinds
  localparam logic [1:0] ITEM_NAME   = 2'd0;
  localparam logic [1:0] ITEM_VALUE  = 2'd1;
  localparam logic [1:0] ITEM_VSTART = 2'd2;
  localparam logic [1:0] ITEM_FEND   = 2'd3;

  // Escape hold states
  localparam logic [1:0] PEND_NONE  = 2'd0;
  localparam logic [1:0] PEND_PCT   = 2'd1;
  localparam logic [1:0] PEND_DIGIT = 2'd2;

  // Special characters
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_SPACE = 8'h20;

  localparam int MaxItems = 4;
  localparam int CntW     = $clog2(MaxItems + 1);
  localparam int IdxW     = $clog2(MaxItems);

  typedef struct packed {
    logic [7:0] data;
    logic [1:0] kind;
    logic       qend;
  } uqd_item_t;

  // All results caused by one input byte
  typedef struct packed {
    logic [CntW-1:0]             cnt;
    uqd_item_t [MaxItems-1:0]    items;
  } uqd_bundle_t;

  // FIFO handshake between front and back
  typedef struct packed {
    logic full;
    logic empty;
  } uqd_fifo_status_t;

  function automatic logic is_hex(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
           (c >= 8'h61 && c <= 8'h66);
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [7:0] v;
    v = 8'd0;
    if (c >= 8'h41 && c <= 8'h46) v = c - 8'h37;
    else if (c >= 8'h61 && c <= 8'h66) v = c - 8'h57;
    else if (c >= 8'h30 && c <= 8'h39) v = c - 8'h30;
    return v[3:0];
  endfunction

  function automatic uqd_item_t mk_item(input logic [7:0] data, input logic [1:0] kind,
                                        input logic qend);
    uqd_item_t it;
    it.data = data;
    it.kind = kind;
    it.qend = qend;
    return it;
  endfunction

endpackage

// ===== rtl/url_query_decoder_core.sv =====
// Each byte's results are registered as one bundle, offered behind any queued before it.
// Throughput: one input byte per cycle while each byte yields at most one result and
// out_stall is low; a byte with more results holds the output for one beat per result,
// buffered by a two-deep queue. Bytes that only start or extend an escape yield nothing.
// Reset (rst_n low, synchronous) empties the queue and returns to the name part
// with no escape held.
module url_query_decoder_core (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_query_last,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic [1:0] out_item_type,
  output logic       out_query_end,
  output logic       out_run_last
);
  import uqd_pkg::*;

  uqd_bundle_t      wr_bundle, head;
  uqd_fifo_status_t fifo_st;
  logic             push, pop;

  uqd_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_byte       (in_byte),
    .in_query_last (in_query_last),
    .fifo_st       (fifo_st),
    .push          (push),
    .bundle        (wr_bundle)
  );

  uqd_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .wr_bundle (wr_bundle),
    .pop       (pop),
    .rd_bundle (head),
    .status    (fifo_st)
  );

  uqd_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .head          (head),
    .fifo_st       (fifo_st),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_byte      (out_byte),
    .out_item_type (out_item_type),
    .out_query_end (out_query_end),
    .out_run_last  (out_run_last)
  );

endmodule

// ===== rtl/uqd_front.sv =====
module uqd_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [7:0]            in_byte,
  input  logic                  in_query_last,
  input  uqd_pkg::uqd_fifo_status_t fifo_st,
  output logic                  push,
  output uqd_pkg::uqd_bundle_t  bundle
);
  import uqd_pkg::*;

  logic [1:0] pend_r, pend_nxt;
  logic [7:0] held_r, held_nxt;
  logic       inval_r, inval_nxt;
  logic       accept;

  uqd_item_t [MaxItems-1:0] slots;
  logic [CntW-1:0]          cnt;

  assign in_stall = fifo_st.full;
  assign accept   = in_valid && !fifo_st.full;

  // Classify one byte into up to four results
  always_comb begin
    slots     = '0;
    cnt       = '0;
    pend_nxt  = pend_r;
    held_nxt  = held_r;
    inval_nxt = inval_r;
    if (pend_r == PEND_PCT && is_hex(in_byte)) begin
      held_nxt = in_byte;
      pend_nxt = PEND_DIGIT;
    end else if (pend_r == PEND_DIGIT && is_hex(in_byte)) begin
      slots[cnt[IdxW-1:0]] = mk_item({hex_val(held_r), hex_val(in_byte)},
                                     inval_r ? ITEM_VALUE : ITEM_NAME, 1'b0);
      cnt      = cnt + 1'b1;
      pend_nxt = PEND_NONE;
      held_nxt = '0;
    end else begin
      // broken escape goes out literally
      if (pend_r == PEND_PCT || pend_r == PEND_DIGIT) begin
        slots[cnt[IdxW-1:0]] = mk_item(CH_PCT, inval_r ? ITEM_VALUE : ITEM_NAME, 1'b0);
        cnt = cnt + 1'b1;
      end
      if (pend_r == PEND_DIGIT) begin
        slots[cnt[IdxW-1:0]] = mk_item(held_r, inval_r ? ITEM_VALUE : ITEM_NAME, 1'b0);
        cnt = cnt + 1'b1;
      end
      pend_nxt = PEND_NONE;
      held_nxt = '0;
      // plain byte handling
      if (in_byte == CH_AMP) begin
        slots[cnt[IdxW-1:0]] = mk_item(8'd0, ITEM_FEND, 1'b0);
        cnt       = cnt + 1'b1;
        inval_nxt = 1'b0;
      end else if (in_byte == CH_PLUS) begin
        slots[cnt[IdxW-1:0]] = mk_item(CH_SPACE, inval_r ? ITEM_VALUE : ITEM_NAME, 1'b0);
        cnt = cnt + 1'b1;
      end else if (in_byte == CH_PCT) begin
        pend_nxt = PEND_PCT;
      end else if (in_byte == CH_EQ && !inval_r) begin
        slots[cnt[IdxW-1:0]] = mk_item(8'd0, ITEM_VSTART, 1'b0);
        cnt       = cnt + 1'b1;
        inval_nxt = 1'b1;
      end else begin
        slots[cnt[IdxW-1:0]] = mk_item(in_byte, inval_r ? ITEM_VALUE : ITEM_NAME, 1'b0);
        cnt = cnt + 1'b1;
      end
    end
    // final byte: flush anything held, then close the query
    if (in_query_last) begin
      if (pend_nxt == PEND_PCT || pend_nxt == PEND_DIGIT) begin
        slots[cnt[IdxW-1:0]] = mk_item(CH_PCT, inval_nxt ? ITEM_VALUE : ITEM_NAME, 1'b0);
        cnt = cnt + 1'b1;
      end
      if (pend_nxt == PEND_DIGIT) begin
        slots[cnt[IdxW-1:0]] = mk_item(held_nxt, inval_nxt ? ITEM_VALUE : ITEM_NAME, 1'b0);
        cnt = cnt + 1'b1;
      end
      slots[cnt[IdxW-1:0]] = mk_item(8'd0, ITEM_FEND, 1'b1);
      cnt       = cnt + 1'b1;
      pend_nxt  = PEND_NONE;
      held_nxt  = '0;
      inval_nxt = 1'b0;
    end
  end

  assign bundle.cnt   = cnt;
  assign bundle.items = slots;
  assign push         = accept && (cnt != '0);

  // Decoder state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r  <= PEND_NONE;
      held_r  <= '0;
      inval_r <= 1'b0;
    end else if (accept) begin
      pend_r  <= pend_nxt;
      held_r  <= held_nxt;
      inval_r <= inval_nxt;
    end
  end

endmodule

// ===== rtl/uqd_fifo.sv =====
module uqd_fifo (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      push,
  input  uqd_pkg::uqd_bundle_t      wr_bundle,
  input  logic                      pop,
  output uqd_pkg::uqd_bundle_t      rd_bundle,
  output uqd_pkg::uqd_fifo_status_t status
);
  import uqd_pkg::*;

  uqd_bundle_t mem_r [2];
  logic        wr_ptr_r, rd_ptr_r;
  logic [1:0]  count_r;

  assign status.full  = (count_r == 2'd2);
  assign status.empty = (count_r == 2'd0);
  assign rd_bundle    = mem_r[rd_ptr_r];

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_bundle;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      case ({push, pop})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

// ===== rtl/uqd_back.sv =====
module uqd_back (
  input  logic                      clk,
  input  logic                      rst_n,
  input  uqd_pkg::uqd_bundle_t      head,
  input  uqd_pkg::uqd_fifo_status_t fifo_st,
  output logic                      pop,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [7:0]                out_byte,
  output logic [1:0]                out_item_type,
  output logic                      out_query_end,
  output logic                      out_run_last
);
  import uqd_pkg::*;

  logic [IdxW-1:0] idx_r, idx_nxt;
  logic            beat;
  logic            last_item;
  uqd_item_t       cur;

  assign cur       = head.items[idx_r];
  assign last_item = ({1'b0, idx_r} == head.cnt - 1'b1);
  assign out_valid = !fifo_st.empty;
  assign beat      = out_valid && !out_stall;
  assign pop       = beat && last_item;

  assign out_byte      = cur.data;
  assign out_item_type = cur.kind;
  assign out_query_end = cur.qend;
  assign out_run_last  = last_item;

  // Step through the head bundle one beat at a time
  always_comb begin
    idx_nxt = idx_r;
    if (beat) idx_nxt = last_item ? '0 : idx_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
    end else begin
      idx_r <= idx_nxt;
    end
  end

endmodule
